@@ rtl/core/sks_pkg.sv @@
// Shared types and constants for the sorted key binary search block.
package sks_pkg;

    localparam int KEY_W = 64;
    localparam int OP_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_PROBE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // append key at fill count
        logic clear;      // empty the table
        logic init;       // latch key, set search window to whole table
        logic issue;      // read first probe
        logic step;       // narrow window from probe, read next probe
        logic finish;     // capture found
        logic found_val;
    } sks_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
        logic hit;
        logic range_empty;
    } sks_stat_t;

endpackage

@@ rtl/core/sks_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sks_datapath.sv @@
// Datapath: key table, fill count, search window and probe compare.
module sks_datapath #(
    parameter int TABLE_DEPTH = 512,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sks_pkg::KEY_W-1:0] key,
    input  sks_pkg::sks_cmd_t        cmd,
    output sks_pkg::sks_stat_t       stat,
    output logic                     found
);
    import sks_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             found_reg, found_next;

    logic [KEY_W-1:0] probe;
    logic             hit;
    logic             below;
    logic             full;
    logic [CNT_W-1:0] lo_step;
    logic [CNT_W-1:0] hi_step;
    logic [CNT_W-1:0] lo_src;
    logic [CNT_W-1:0] hi_src;
    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid_calc;
    logic             we;

    sks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key),
        .raddr (mid_calc),
        .rdata (probe)
    );

    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign we    = cmd.load && !full;
    assign hit   = (probe == key_reg);
    assign below = (probe < key_reg);

    // window after this probe: [lo, hi) exclusive upper bound
    assign lo_step = below ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign hi_step = below ? hi_reg : CNT_W'(mid_reg);

    assign lo_src   = cmd.step ? lo_step : lo_reg;
    assign hi_src   = cmd.step ? hi_step : hi_reg;
    assign mid_sum  = {1'b0, lo_src} + {1'b0, hi_src} - (CNT_W + 1)'(1);
    assign mid_calc = mid_sum[IDX_W:1];

    assign stat.cnt_zero    = (count_reg == '0);
    assign stat.hit         = hit;
    assign stat.range_empty = !(lo_step < hi_step);

    assign found = found_reg;

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        if (we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        if (cmd.init)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            key_next = key;
        end
        if (cmd.issue)
        begin
            mid_next = mid_calc;
        end
        if (cmd.step && !cmd.finish)
        begin
            lo_next  = lo_step;
            hi_next  = hi_step;
            mid_next = mid_calc;
        end
        if (cmd.finish)
        begin
            found_next = cmd.found_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

endmodule

@@ rtl/core/sks_ctrl.sv @@
// Controller: accepts commands and sequences the probe loop of a search.
module sks_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sks_pkg::OP_W-1:0]  op,
    input  sks_pkg::sks_stat_t        stat,
    output sks_pkg::sks_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);
    import sks_pkg::*;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   accept;
    op_t    op_in;

    assign op_in  = op_t'(op);
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op_in == OP_SEARCH) && !stat.cnt_zero)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (stat.hit || stat.range_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_LOAD:  cmd.load  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_SEARCH:
                        begin
                            cmd.init = 1'b1;
                            // empty table answers at once
                            if (stat.cnt_zero)
                            begin
                                cmd.finish    = 1'b1;
                                cmd.found_val = 1'b0;
                                done_next     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
            end
            ST_PROBE:
            begin
                cmd.step = 1'b1;
                if (stat.hit || stat.range_empty)
                begin
                    cmd.finish    = 1'b1;
                    cmd.found_val = stat.hit;
                    done_next     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ rtl/core/sorted_key_binary_search.sv @@
// Top level: sorted key table with binary search membership lookup.
//
//  channel | ports          | handshake                        | width
//  --------+----------------+----------------------------------+-----------
//  command | op, key        | start high while busy low        | 2 + 64
//  result  | found          | done high for one cycle          | 1
//
//  Load, clear and unused op codes complete when accepted; busy stays low.
//  A search makes P probes (at most clog2(TABLE_DEPTH) + 1): the issue state
//  starts the first table read, then the probe state makes one probe per
//  cycle through the table RAM read port.
//  An empty table is answered without going busy. done and found are registered; a
//  new beat may be accepted in the cycle done is shown.
//  Reset clears the fill count and controller; table contents stay.
module sorted_key_binary_search #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sks_pkg::OP_W-1:0]  op,
    input  logic [sks_pkg::KEY_W-1:0] key,
    output logic                      busy,
    output logic                      done,
    output logic                      found
);
    import sks_pkg::*;

    sks_cmd_t  cmd;
    sks_stat_t stat;

    sks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sks_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key),
        .cmd   (cmd),
        .stat  (stat),
        .found (found)
    );

endmodule

@@ rtl/core/sks_checker.sv @@
// Port-level checks for the binary search block, bound to the top level.
module sks_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic [sks_pkg::OP_W-1:0] op,
    input logic                     busy,
    input logic                     done
);
    import sks_pkg::*;

    // a search beat either goes busy or answers at once
    a_search_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_SEARCH)) |=> (busy || done))
        else $error("search beat neither busy nor done");

    // non-search beats give no result and leave the block idle
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_SEARCH)) |=> (!busy && !done))
        else $error("result or busy after non-search beat");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a search only ends with its result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without done");

endmodule

bind sorted_key_binary_search sks_checker u_sks_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (op),
    .busy  (busy),
    .done  (done)
);
